### hw/rtl/ptlr_pkg.sv
package ptlr_pkg;

    localparam int LBA_W  = 64;
    localparam int GUID_W = 64;
    localparam int SLOT_W = 7;
    localparam int FUNC_W = 2;
    localparam int STAT_W = 3;

    // slot numbers are 7 bits wide, so the table never holds more than this
    localparam int SLOT_LIMIT = 128;

    localparam logic [GUID_W-1:0] GUID_FLOOR_RESET = 64'h0000_1000_0000_0000;

    // function code 3 is handled as an access, like read and write
    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_WRITE = 2'd2
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_ZERO_GUID = 3'd1,
        ST_ZERO_TYPE = 3'd2,
        ST_GUID_LOW  = 3'd3,
        ST_FULL      = 3'd4,
        ST_RANGE     = 3'd5,
        ST_UNLOADED  = 3'd6
    } t_status;

    // what the first stage hands to the result stage
    typedef struct packed {
        logic                is_load;
        t_status             load_status;
        logic                unloaded;
        logic [SLOT_W-1:0]   slot;
        logic [LBA_W-1:0]    rel_lba;
    } t_stage_a;

endpackage

### hw/rtl/partition_table_lba_remap_unit.sv
// Partition table LBA remapper.
//
// Input channel (i_in_valid / o_in_ready) carries one item per handshake:
// a load (i_func = load) offering a partition entry, or an access (read,
// write, or the unused code 3) naming i_part_slot and i_rel_lba.
// Output channel (o_out_valid / i_out_ready) returns exactly one result per
// item, in order: status, slot, absolute LBA and sector count.
// i_cfg_we writes i_cfg_wdata into the GUID floor register; write it only
// while the block is idle.
//
// The accept edge checks a load and writes the bound tables, or reads both
// tables for an access; stage B then does the range add/compare, and the
// result register is loaded from it once the output is free.
// Throughput: one item per cycle while the receiver does not stall the
// output; each table is written or read once per item at the accept edge.
// Reset (synchronous, active low) empties the pipeline, clears the slot
// count and restores the GUID floor. Table contents are not cleared; slots
// at or above the count are reported as unloaded.
// A stalled receiver holds the result register; the first stage still takes
// one more item, then o_in_ready drops until the output drains.
module partition_table_lba_remap_unit #(
    parameter int MAX_PARTITIONS = 128
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_cfg_we,
    input  logic [ptlr_pkg::GUID_W-1:0]   i_cfg_wdata,

    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [ptlr_pkg::FUNC_W-1:0]   i_func,
    input  logic [ptlr_pkg::GUID_W-1:0]   i_guid_low,
    input  logic [ptlr_pkg::GUID_W-1:0]   i_guid_high,
    input  logic [ptlr_pkg::GUID_W-1:0]   i_type_low,
    input  logic [ptlr_pkg::GUID_W-1:0]   i_type_high,
    input  logic [ptlr_pkg::LBA_W-1:0]    i_first_lba,
    input  logic [ptlr_pkg::LBA_W-1:0]    i_last_lba,
    input  logic [ptlr_pkg::SLOT_W-1:0]   i_part_slot,
    input  logic [ptlr_pkg::LBA_W-1:0]    i_rel_lba,

    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [ptlr_pkg::STAT_W-1:0]   o_status,
    output logic [ptlr_pkg::SLOT_W-1:0]   o_slot_index,
    output logic [ptlr_pkg::LBA_W-1:0]    o_abs_lba,
    output logic [ptlr_pkg::LBA_W-1:0]    o_sector_total
);

    // usable slots: limited by the 7-bit slot field
    localparam int CAP       = (MAX_PARTITIONS < ptlr_pkg::SLOT_LIMIT) ?
                               MAX_PARTITIONS : ptlr_pkg::SLOT_LIMIT;
    localparam int CNT_W     = $clog2(CAP + 1);
    localparam int ADDR_W    = (CAP > 1) ? $clog2(CAP) : 1;
    localparam int MEM_DEPTH = 1 << ADDR_W;
    localparam int LBA_W     = ptlr_pkg::LBA_W;
    localparam int SLOT_W    = ptlr_pkg::SLOT_W;
    localparam int CMP_W     = ptlr_pkg::SLOT_W + 1;

    // ---------------------------------------------------------------
    // state
    // ---------------------------------------------------------------
    logic [ptlr_pkg::GUID_W-1:0] r_min_guid;
    logic [CNT_W-1:0]            r_slots_used;
    logic [CNT_W-1:0]            n_slots_used;

    logic [LBA_W-1:0] r_start_mem [0:MEM_DEPTH-1];
    logic [LBA_W-1:0] r_end_mem   [0:MEM_DEPTH-1];
    logic [LBA_W-1:0] r_rd_start;
    logic [LBA_W-1:0] r_rd_end;

    logic                r_a_valid;
    ptlr_pkg::t_stage_a  r_a;
    ptlr_pkg::t_stage_a  n_a;

    logic                r_out_valid;
    ptlr_pkg::t_status   r_status;
    logic [SLOT_W-1:0]   r_slot_index;
    logic [LBA_W-1:0]    r_abs_lba;
    logic [LBA_W-1:0]    r_sector_total;

    // ---------------------------------------------------------------
    // handshake
    // ---------------------------------------------------------------
    logic out_free;
    logic a_adv;
    logic in_acc;

    assign out_free   = !r_out_valid || i_out_ready;
    assign a_adv      = r_a_valid && out_free;
    assign o_in_ready = !r_a_valid || out_free;
    assign in_acc     = i_in_valid && o_in_ready;

    // ---------------------------------------------------------------
    // stage A: load checks / table access
    // ---------------------------------------------------------------
    logic is_load;
    logic load_ok;
    logic tbl_full;

    assign is_load  = (i_func == ptlr_pkg::FUNC_LOAD);
    assign tbl_full = (r_slots_used >= CNT_W'(CAP));

    always_comb begin
        n_a             = '0;
        n_a.is_load     = is_load;
        n_a.rel_lba     = i_rel_lba;
        n_a.load_status = ptlr_pkg::ST_OK;
        load_ok         = 1'b0;
        // checks in priority order; first failure wins
        if (i_guid_low == '0 && i_guid_high == '0) begin
            n_a.load_status = ptlr_pkg::ST_ZERO_GUID;
        end else if (i_type_low == '0 && i_type_high == '0) begin
            n_a.load_status = ptlr_pkg::ST_ZERO_TYPE;
        end else if (i_guid_low < r_min_guid || i_guid_high < r_min_guid) begin
            n_a.load_status = ptlr_pkg::ST_GUID_LOW;
        end else if (tbl_full) begin
            n_a.load_status = ptlr_pkg::ST_FULL;
        end else begin
            load_ok = 1'b1;
        end
        if (is_load) begin
            n_a.slot     = load_ok ? SLOT_W'(r_slots_used) : '0;
            n_a.unloaded = 1'b0;
        end else begin
            n_a.slot     = i_part_slot;
            n_a.unloaded = ({1'b0, i_part_slot} >= CMP_W'(r_slots_used));
        end
    end

    assign n_slots_used = r_slots_used + CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_guid   <= ptlr_pkg::GUID_FLOOR_RESET;
            r_slots_used <= '0;
            r_a_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_min_guid <= i_cfg_wdata;
            end
            if (in_acc && is_load && load_ok) begin
                r_slots_used <= n_slots_used;
            end
            if (in_acc) begin
                r_a_valid <= 1'b1;
            end else if (a_adv) begin
                r_a_valid <= 1'b0;
            end
        end
    end

    // bound tables: written by an accepted load, read by an access
    always_ff @(posedge i_clk) begin
        if (in_acc && is_load && load_ok) begin
            r_start_mem[r_slots_used[ADDR_W-1:0]] <= i_first_lba;
            r_end_mem[r_slots_used[ADDR_W-1:0]]   <= i_last_lba;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a        <= n_a;
            r_rd_start <= r_start_mem[i_part_slot[ADDR_W-1:0]];
            r_rd_end   <= r_end_mem[i_part_slot[ADDR_W-1:0]];
        end
    end

    // ---------------------------------------------------------------
    // stage B: sector count, range check, absolute LBA
    // ---------------------------------------------------------------
    logic              inverted;
    logic              span_sat;
    logic [LBA_W:0]    abs_sum;
    logic              in_range;
    logic [LBA_W-1:0]  total;

    ptlr_pkg::t_status n_status;
    logic [LBA_W-1:0]  n_abs_lba;
    logic [LBA_W-1:0]  n_sector_total;

    assign inverted = (r_rd_end < r_rd_start);
    // end - start + 1 overflows only for the full 0..max span
    assign span_sat = (r_rd_start == '0) && (&r_rd_end);
    assign abs_sum  = {1'b0, r_rd_start} + {1'b0, r_a.rel_lba};

    always_comb begin
        if (inverted) begin
            total = '0;
        end else if (span_sat) begin
            total = '1;
        end else begin
            total = r_rd_end - r_rd_start + LBA_W'(1);
        end
    end

    // rel < end - start + 1  <=>  start + rel <= end (no wrap in 65 bits);
    // the saturated span excludes only rel = max
    assign in_range = !inverted && (abs_sum <= {1'b0, r_rd_end}) &&
                      !(span_sat && (&r_a.rel_lba));

    always_comb begin
        n_status       = ptlr_pkg::ST_OK;
        n_abs_lba      = '0;
        n_sector_total = '0;
        if (r_a.is_load) begin
            n_status = r_a.load_status;
        end else if (r_a.unloaded) begin
            n_status = ptlr_pkg::ST_UNLOADED;
        end else begin
            n_sector_total = total;
            if (in_range) begin
                n_abs_lba = abs_sum[LBA_W-1:0];
            end else begin
                n_status = ptlr_pkg::ST_RANGE;
            end
        end
    end

    // ---------------------------------------------------------------
    // result register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_status       <= n_status;
            r_slot_index   <= r_a.slot;
            r_abs_lba      <= n_abs_lba;
            r_sector_total <= n_sector_total;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_slot_index   = r_slot_index;
    assign o_abs_lba      = r_abs_lba;
    assign o_sector_total = r_sector_total;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    a_slots_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slots_used <= CNT_W'(CAP))
        else $error("slot count above capacity");

    a_slots_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (r_slots_used != $past(r_slots_used)) |->
            (r_slots_used == $past(r_slots_used) + CNT_W'(1)))
        else $error("slot count moved by more than one");

    a_rd_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && !a_adv && !in_acc |=> $stable(r_rd_start) && $stable(r_rd_end))
        else $error("table read data changed while stage A stalled");

    a_unloaded_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_status == ptlr_pkg::ST_UNLOADED) |->
            (r_abs_lba == '0) && (r_sector_total == '0))
        else $error("unloaded slot reported nonzero LBA or count");

    a_range_lba_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_status == ptlr_pkg::ST_RANGE) |-> (r_abs_lba == '0))
        else $error("out of range access reported an LBA");

endmodule
